@@ rtl/bpdc_pkg.sv @@
// Shared types and constants for the button press duration classifier.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bpdc_pkg;

    // Default width of each button's hold counter.
    localparam int HOLD_COUNT_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD  = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_DATA_W-1:0] CLICK_MIN_RST = 8'd2;
    localparam logic [CFG_DATA_W-1:0] HOLD_MIN_RST  = 8'd24;
    localparam logic [CFG_DATA_W-1:0] OFF_HOLD_RST  = 8'd98;

    // One input beat: both button levels, 0 pressed, 1 released.
    typedef struct packed {
        logic left_level;
        logic right_level;
    } tick_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] effect_index;
        logic [7:0] palette_index;
        logic       lights_off;
        logic       standby_request;
    } result_t;

    // Current thresholds.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] click_min;
        logic [CFG_DATA_W-1:0] hold_min;
        logic [CFG_DATA_W-1:0] off_hold;
    } cfg_t;

    // What one button did on one tick.
    typedef struct packed {
        logic effect_step;
        logic palette_step;
        logic standby;
        logic off_set;
    } btn_evt_t;

endpackage

`default_nettype wire

@@ rtl/bpdc_cfg.sv @@
// Configuration register file for the button press duration classifier.
// Depends on bpdc_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module bpdc_cfg
    import bpdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLICK_MIN: cfg_next.click_min = cfg_data;
                CFG_HOLD_MIN:  cfg_next.hold_min  = cfg_data;
                CFG_OFF_HOLD:  cfg_next.off_hold  = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_min <= CLICK_MIN_RST;
            cfg_reg.hold_min  <= HOLD_MIN_RST;
            cfg_reg.off_hold  <= OFF_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/bpdc_button.sv @@
// One button's level tracker, saturating hold counter and release classifier.
// Depends on bpdc_pkg for cfg_t and btn_evt_t.
`default_nettype none

module bpdc_button
    import bpdc_pkg::*;
#(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic level,
    input  wire cfg_t cfg,
    output btn_evt_t  evt
);

    logic                       last_level_reg;
    logic                       last_level_next;
    logic [HOLD_COUNT_BITS-1:0] hold_count_reg;
    logic [HOLD_COUNT_BITS-1:0] hold_count_next;
    logic [HOLD_COUNT_BITS-1:0] click_min_w;
    logic [HOLD_COUNT_BITS-1:0] hold_min_w;
    logic [HOLD_COUNT_BITS-1:0] off_hold_w;
    logic                       below_off;
    logic                       below_hold;
    logic                       below_click;

    assign click_min_w = HOLD_COUNT_BITS'(cfg.click_min);
    assign hold_min_w  = HOLD_COUNT_BITS'(cfg.hold_min);
    assign off_hold_w  = HOLD_COUNT_BITS'(cfg.off_hold);

    assign below_off   = hold_count_reg < off_hold_w;
    assign below_hold  = hold_count_reg < hold_min_w;
    assign below_click = hold_count_reg < click_min_w;

    always_comb
    begin
        evt             = '0;
        hold_count_next = hold_count_reg;
        last_level_next = level;
        if (level != last_level_reg)
        begin
            if (!last_level_reg)
            begin
                // Release: the effect window takes priority over the palette window.
                if (below_off && !below_hold)
                begin
                    evt.effect_step = 1'b1;
                end
                else if (below_hold && !below_click)
                begin
                    evt.palette_step = 1'b1;
                end
            end
            else
            begin
                evt.standby     = !below_off;
                hold_count_next = '0;
            end
        end
        else if (!level)
        begin
            evt.off_set = !below_off;
            if (hold_count_reg != '1)
            begin
                hold_count_next = hold_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b0;
            hold_count_reg <= '0;
        end
        else if (step)
        begin
            last_level_reg <= last_level_next;
            hold_count_reg <= hold_count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/button_press_duration_classifier.sv @@
// Top level of the button press duration classifier.
// Depends on bpdc_pkg, bpdc_cfg and bpdc_button.
`default_nettype none

// The classifier takes one beat per periodic tick, each carrying the levels of
// two active-low buttons, and returns exactly one result beat for it: the
// effect and palette counters after the tick, the sticky lights-off flag and
// a standby request. A release after a hold of at least hold_min and below
// off_hold steps the effect counter; a release after a hold of at least
// click_min and below hold_min steps the palette counter. The left button
// steps down and the right one steps up, both wrapping at 8 bits. A new press
// clears that button's hold counter and raises standby_request if the hold
// before it reached off_hold; holding at or past off_hold sets lights_off,
// which stays set until reset. After reset both buttons read as pressed, so a
// released level on the first tick counts as a release with a hold of zero.
// Throughput is one tick beat per clock cycle unless the result channel stalls:
// the classification is a few compares and an 8-bit add, done in a single pass
// from the input register to the result register. The input register keeps
// taking a beat while the result register holds a stalled one, so tick_stall
// rises only once both are full. The user writes thresholds through the
// cfg_we port only while no tick is in flight; the block does not enforce it.

module button_press_duration_classifier
    import bpdc_pkg::*;
#(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Tick channel.
    input  wire logic                  tick_valid,
    output logic                       tick_stall,
    input  wire tick_t                 tick,
    // Result channel.
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg;
    btn_evt_t left_evt;
    btn_evt_t right_evt;

    // Input register stage.
    logic    s1_valid_reg;
    logic    s1_valid_next;
    tick_t   s1_tick_reg;
    logic    tick_accept;
    logic    advance;

    // Shared counters and flag.
    logic [7:0] effect_count_reg;
    logic [7:0] effect_count_next;
    logic [7:0] palette_count_reg;
    logic [7:0] palette_count_next;
    logic       off_flag_reg;
    logic       off_flag_next;

    // Result register stage.
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    result_t result_next;

    // The input register moves into the result register whenever the result
    // register is empty or its beat is being taken in this cycle.
    assign advance     = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign tick_stall  = s1_valid_reg && !advance;
    assign tick_accept = tick_valid && !tick_stall;

    assign s1_valid_next     = tick_accept || (s1_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    bpdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpdc_button #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (s1_tick_reg.left_level),
        .cfg   (cfg),
        .evt   (left_evt)
    );

    bpdc_button #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (s1_tick_reg.right_level),
        .cfg   (cfg),
        .evt   (right_evt)
    );

    // Left steps down and right steps up. Both steps commute under 8-bit wrap,
    // so the left-then-right order of the buttons folds into one sum.
    assign effect_count_next  = effect_count_reg - {7'd0, left_evt.effect_step}
                                + {7'd0, right_evt.effect_step};
    assign palette_count_next = palette_count_reg - {7'd0, left_evt.palette_step}
                                + {7'd0, right_evt.palette_step};
    assign off_flag_next      = off_flag_reg || left_evt.off_set || right_evt.off_set;

    always_comb
    begin
        result_next.effect_index    = effect_count_next;
        result_next.palette_index   = palette_count_next;
        result_next.lights_off      = off_flag_next;
        result_next.standby_request = left_evt.standby || right_evt.standby;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            result_valid_reg  <= 1'b0;
            effect_count_reg  <= '0;
            palette_count_reg <= '0;
            off_flag_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                effect_count_reg  <= effect_count_next;
                palette_count_reg <= palette_count_next;
                off_flag_reg      <= off_flag_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_tick_reg <= tick;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // The tick channel stalls only when both stages are full and the result
    // side holds back.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> (s1_valid_reg && result_valid_reg && result_stall))
        else $error("tick_stall raised while a stage had room");

    // Once set, the lights-off flag never clears.
    a_off_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        off_flag_reg |=> off_flag_reg)
        else $error("lights-off flag cleared without reset");

    // A beat moved out of the input register shows up as a result next cycle.
    a_advance_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_valid_reg && result_reg.lights_off == off_flag_reg))
        else $error("advanced beat missing from the result register");
`endif

endmodule

`default_nettype wire
